@@ hw/rtl/tbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared widths, codes, types and the wrap helper for the texture sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int CHAN_W   = 16;
  localparam int TEXEL_W  = 4 * CHAN_W;
  localparam int STORE_AW = 16;
  localparam int COORD_W  = 25;
  localparam int SIZE_W   = 9;
  localparam int FRAC_W   = 16;
  localparam int KINT_W   = 10;   // integer part of a coordinate
  localparam int FL_W     = 21;   // floor of a scaled coordinate
  localparam int CFG_AW   = 2;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WRAP_X     = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_WRAP_Y     = 2'd3;

  // wrap modes; the unused code behaves as mirror
  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  // request types
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] i0;
    logic [SIZE_W-1:0] i1;
  } idx_pair_t;

  // Wrap both neighbor indices of one axis.
  // fi  : full floor, k*size + g
  // g   : floor of the fractional part times size, in -1 .. size-1
  // par : parity of k, picks the mirror half for mirror mode
  function automatic idx_pair_t wrap_pair(input logic signed [FL_W-1:0] fi,
                                          input logic signed [KINT_W-1:0] g,
                                          input logic par,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [1:0] mode);
    idx_pair_t               res;
    logic signed [FL_W:0]    fi0;
    logic signed [FL_W:0]    fi1;
    logic signed [FL_W:0]    ssz;
    logic signed [11:0]      t0;
    logic signed [11:0]      t1;
    logic signed [11:0]      per;
    logic signed [11:0]      r0;
    logic signed [11:0]      r1;
    logic signed [11:0]      sz12;
    logic signed [11:0]      g12;
    fi0  = {fi[FL_W-1], fi};
    fi1  = fi0 + 22'sd1;
    ssz  = $signed({{(FL_W+1-SIZE_W){1'b0}}, size});
    sz12 = $signed({3'b000, size});
    g12  = {{2{g[KINT_W-1]}}, g};
    per  = sz12 + sz12;
    t0   = (par ? sz12 : 12'sd0) + g12;
    t1   = t0 + 12'sd1;
    r0   = (t0 < 12'sd0) ? per - 12'sd1 : t0;
    r1   = (t1 == per) ? 12'sd0 : t1;
    res  = '0;
    case (mode)
      WRAP_CLAMP: begin
        res.i0 = (fi0 < 0) ? '0 : (fi0 >= ssz) ? size - 9'd1 : fi0[SIZE_W-1:0];
        res.i1 = (fi1 < 0) ? '0 : (fi1 >= ssz) ? size - 9'd1 : fi1[SIZE_W-1:0];
      end
      WRAP_REPEAT: begin
        res.i0 = (g12 < 12'sd0) ? size - 9'd1 : g12[SIZE_W-1:0];
        res.i1 = ((g12 + 12'sd1) == sz12) ? '0 : 9'(g12 + 12'sd1);
      end
      default: begin
        res.i0 = (r0 < sz12) ? r0[SIZE_W-1:0] : 9'(per - 12'sd1 - r0);
        res.i1 = (r1 < sz12) ? r1[SIZE_W-1:0] : 9'(per - 12'sd1 - r1);
      end
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/tbs_ram.sv @@
// ----------------------------------------------------------------------------
// tbs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/bilinear_texture_sampler_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core
// Bilinear RGBA16 texture sampler with clamp / repeat / mirror wrap per axis.
// ----------------------------------------------------------------------------
// Pipeline: a sample passes the stage 1 to 5 registers, then the output register, to the result port.
// Throughput: one request per cycle; the whole pipeline stalls together
//   while a result waits on out_ready. The four texel reads come from two
//   dual-read copies of the texel store, written in parallel.
// Reset: clears valid bits and sets width/height 1, clamp; the texel
//   store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [tbs_pkg::CFG_AW-1:0]       cfg_index,
  input  logic [tbs_pkg::SIZE_W-1:0]       cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [tbs_pkg::STORE_AW-1:0]     in_texel_index,
  input  logic [tbs_pkg::CHAN_W-1:0]       in_texel_red,
  input  logic [tbs_pkg::CHAN_W-1:0]       in_texel_green,
  input  logic [tbs_pkg::CHAN_W-1:0]       in_texel_blue,
  input  logic [tbs_pkg::CHAN_W-1:0]       in_texel_alpha,
  input  logic signed [tbs_pkg::COORD_W-1:0] in_coord_u,
  input  logic signed [tbs_pkg::COORD_W-1:0] in_coord_v,
  input  logic                             in_batch_end,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tbs_pkg::CHAN_W-1:0]       out_red,
  output logic [tbs_pkg::CHAN_W-1:0]       out_green,
  output logic [tbs_pkg::CHAN_W-1:0]       out_blue,
  output logic [tbs_pkg::CHAN_W-1:0]       out_alpha,
  output logic                             out_batch_end_out
);

  import tbs_pkg::*;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [SIZE_W-1:0] tex_width_r, tex_height_r;
  logic [1:0]        wrap_x_r, wrap_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= 9'd1;
      tex_height_r <= 9'd1;
      wrap_x_r     <= WRAP_CLAMP;
      wrap_y_r     <= WRAP_CLAMP;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        CFG_TEX_HEIGHT: tex_height_r <= cfg_data;
        CFG_WRAP_X:     wrap_x_r     <= cfg_data[1:0];
        CFG_WRAP_Y:     wrap_y_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize clamps to the maximum
  logic [SIZE_W-1:0] w_eff, h_eff;
  assign w_eff = (tex_width_r == '0) ? 9'd1 :
                 ({23'b0, tex_width_r} > MAX_WIDTH) ? 9'(MAX_WIDTH) : tex_width_r;
  assign h_eff = (tex_height_r == '0) ? 9'd1 :
                 ({23'b0, tex_height_r} > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : tex_height_r;

  // --------------------------------------------------------------------------
  // global stall: everything moves when the output register can move
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // stage 1: capture request, split u and flipped v into integer and fraction
  logic                     s1_v_r, s1_smp_r, s1_be_r;
  logic [STORE_AW-1:0]      s1_idx_r;
  logic [TEXEL_W-1:0]       s1_tex_r;
  logic signed [KINT_W-1:0] s1_kx_r, s1_ky_r;
  logic [FRAC_W-1:0]        s1_rx_r, s1_ry_r;
  logic signed [COORD_W:0]  vflip;

  assign vflip = 26'sd65536 - {in_coord_v[COORD_W-1], in_coord_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_smp_r <= (in_req_type == REQ_SAMPLE);
      s1_be_r  <= in_batch_end;
      s1_idx_r <= in_texel_index;
      s1_tex_r <= {in_texel_alpha, in_texel_blue, in_texel_green, in_texel_red};
      s1_kx_r  <= {in_coord_u[COORD_W-1], in_coord_u[COORD_W-1:FRAC_W]};
      s1_rx_r  <= in_coord_u[FRAC_W-1:0];
      s1_ky_r  <= vflip[COORD_W:FRAC_W];
      s1_ry_r  <= vflip[FRAC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: scale integer and fraction parts by the texture size
  logic                     s2_v_r, s2_smp_r, s2_be_r, s2_px_r, s2_py_r;
  logic [STORE_AW-1:0]      s2_idx_r;
  logic [TEXEL_W-1:0]       s2_tex_r;
  logic [FRAC_W+SIZE_W-1:0] s2_rw_r, s2_rh_r;
  logic signed [2*KINT_W-1:0] s2_kw_r, s2_kh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_smp_r <= s1_smp_r;
      s2_be_r  <= s1_be_r;
      s2_idx_r <= s1_idx_r;
      s2_tex_r <= s1_tex_r;
      s2_px_r  <= s1_kx_r[0];
      s2_py_r  <= s1_ky_r[0];
      s2_rw_r  <= s1_rx_r * w_eff;
      s2_rh_r  <= s1_ry_r * h_eff;
      s2_kw_r  <= s1_kx_r * $signed({1'b0, w_eff});
      s2_kh_r  <= s1_ky_r * $signed({1'b0, h_eff});
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: subtract half a texel, floor / fraction, wrap neighbor indices
  logic signed [FRAC_W+SIZE_W:0] tx, ty;
  logic signed [KINT_W-1:0]      gx, gy;
  logic signed [FL_W-1:0]        fix, fiy;
  idx_pair_t                     wx, wy;

  assign tx  = $signed({1'b0, s2_rw_r}) - 26'sd32768;
  assign ty  = $signed({1'b0, s2_rh_r}) - 26'sd32768;
  assign gx  = tx[FRAC_W+SIZE_W:FRAC_W];
  assign gy  = ty[FRAC_W+SIZE_W:FRAC_W];
  assign fix = {s2_kw_r[2*KINT_W-1], s2_kw_r} + {{(FL_W-KINT_W){gx[KINT_W-1]}}, gx};
  assign fiy = {s2_kh_r[2*KINT_W-1], s2_kh_r} + {{(FL_W-KINT_W){gy[KINT_W-1]}}, gy};
  assign wx  = wrap_pair(fix, gx, s2_px_r, w_eff, wrap_x_r);
  assign wy  = wrap_pair(fiy, gy, s2_py_r, h_eff, wrap_y_r);

  logic                v3_v_r, s3_smp_r, s3_be_r;
  logic [STORE_AW-1:0] s3_idx_r;
  logic [TEXEL_W-1:0]  s3_tex_r;
  idx_pair_t           s3_x_r, s3_y_r;
  logic [FRAC_W-1:0]   s3_fx_r, s3_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_v_r <= 1'b0;
    end else if (adv) begin
      v3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_smp_r <= s2_smp_r;
      s3_be_r  <= s2_be_r;
      s3_idx_r <= s2_idx_r;
      s3_tex_r <= s2_tex_r;
      s3_x_r   <= wx;
      s3_y_r   <= wy;
      s3_fx_r  <= tx[FRAC_W-1:0];
      s3_fy_r  <= ty[FRAC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: texel addresses and store access; writes land here too, so
  // requests see the store in request order
  logic [2*SIZE_W-1:0] row0, row1;
  logic [STORE_AW-1:0] a00, a01, a10, a11;
  logic                st_we;
  logic [TEXEL_W-1:0]  t00, t01, t10, t11;

  assign row0  = s3_y_r.i0 * w_eff;
  assign row1  = s3_y_r.i1 * w_eff;
  assign a00   = 16'(row0 + {9'b0, s3_x_r.i0});
  assign a01   = 16'(row0 + {9'b0, s3_x_r.i1});
  assign a10   = 16'(row1 + {9'b0, s3_x_r.i0});
  assign a11   = 16'(row1 + {9'b0, s3_x_r.i1});
  assign st_we = adv && v3_v_r && !s3_smp_r;

  tbs_ram #(.WIDTH(TEXEL_W), .DEPTH(1 << STORE_AW)) u_ram_top (
    .clk     (clk),
    .we      (st_we),
    .waddr   (s3_idx_r),
    .wdata   (s3_tex_r),
    .re      (adv),
    .raddr_a (a00),
    .raddr_b (a01),
    .rdata_a (t00),
    .rdata_b (t01)
  );

  tbs_ram #(.WIDTH(TEXEL_W), .DEPTH(1 << STORE_AW)) u_ram_bot (
    .clk     (clk),
    .we      (st_we),
    .waddr   (s3_idx_r),
    .wdata   (s3_tex_r),
    .re      (adv),
    .raddr_a (a10),
    .raddr_b (a11),
    .rdata_a (t10),
    .rdata_b (t11)
  );

  logic              s4_v_r, s4_be_r;
  logic [FRAC_W-1:0] s4_fx_r, s4_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= v3_v_r && s3_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_be_r <= s3_be_r;
      s4_fx_r <= s3_fx_r;
      s4_fy_r <= s3_fy_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: horizontal blend of the top and bottom texel pairs
  logic [FRAC_W:0]   ix;
  logic [31:0]       top_nxt [4];
  logic [31:0]       bot_nxt [4];

  assign ix = 17'd65536 - {1'b0, s4_fx_r};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      top_nxt[c] = 32'(t00[c*CHAN_W +: CHAN_W] * ix) +
                   32'(t01[c*CHAN_W +: CHAN_W] * s4_fx_r);
      bot_nxt[c] = 32'(t10[c*CHAN_W +: CHAN_W] * ix) +
                   32'(t11[c*CHAN_W +: CHAN_W] * s4_fx_r);
    end
  end

  logic              s5_v_r, s5_be_r;
  logic [FRAC_W-1:0] s5_fy_r;
  logic [31:0]       s5_top_r [4];
  logic [31:0]       s5_bot_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_be_r  <= s4_be_r;
      s5_fy_r  <= s4_fy_r;
      s5_top_r <= top_nxt;
      s5_bot_r <= bot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: vertical blend, round half up, output register
  logic [FRAC_W:0]   iy;
  logic [47:0]       acc [4];
  logic [CHAN_W-1:0] chan_nxt [4];

  assign iy = 17'd65536 - {1'b0, s5_fy_r};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c]      = 48'(s5_top_r[c] * iy) + 48'(s5_bot_r[c] * s5_fy_r);
      chan_nxt[c] = 16'((acc[c] + 48'h0000_8000_0000) >> 32);
    end
  end

  logic [CHAN_W-1:0] out_chan_r [4];
  logic              out_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan_r <= chan_nxt;
      out_be_r   <= s5_be_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_chan_r[0];
  assign out_green         = out_chan_r[1];
  assign out_blue          = out_chan_r[2];
  assign out_alpha         = out_chan_r[3];
  assign out_batch_end_out = out_be_r;

endmodule

@@ hw/rtl/tbs_checker.sv @@
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks for the texture sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue,
  input logic [15:0] out_alpha,
  input logic        out_batch_end_out
);

  // reset empties the result port
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a free output register means requests are taken
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("request blocked with output free");

  // a waiting result blocks new requests
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue) && $stable(out_alpha) &&
      $stable(out_batch_end_out)))
    else $error("stalled result changed");

endmodule

bind bilinear_texture_sampler_core tbs_checker u_tbs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_red           (out_red),
  .out_green         (out_green),
  .out_blue          (out_blue),
  .out_alpha         (out_alpha),
  .out_batch_end_out (out_batch_end_out)
);

@@ dv/tb_bilinear_texture_sampler_core.sv @@
// ----------------------------------------------------------------------------
// tb_bilinear_texture_sampler_core
// Self-checking bench for the bilinear sampler: a directed table at 1x1, then
// phases of size and wrap settings, each loading the texture area in use and
// then mixing random sample and texel write requests under random stalls.
// ----------------------------------------------------------------------------
module tb_bilinear_texture_sampler_core;
  import tbs_pkg::*;

  typedef struct {
    logic                      kind;
    logic [STORE_AW-1:0]       idx;
    logic [CHAN_W-1:0]         r, g, b, a;
    logic signed [COORD_W-1:0] u, v;
    logic                      be;
  } tex_req_t;

  typedef struct {
    logic [CHAN_W-1:0] r, g, b, a;
    logic              be;
  } pixel_t;

  typedef struct {
    tex_req_t req;
    bit       known;
    pixel_t   pix;
  } dir_row_t;

  localparam int DIR_N     = 9;
  localparam int LIMIT_CYC = 600000;
  localparam int DRAIN_CYC = 12;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_AW-1:0]         cfg_index;
  logic [SIZE_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_req_type;
  logic [STORE_AW-1:0]       in_texel_index;
  logic [CHAN_W-1:0]         in_texel_red, in_texel_green, in_texel_blue, in_texel_alpha;
  logic signed [COORD_W-1:0] in_coord_u, in_coord_v;
  logic                      in_batch_end;
  logic                      out_valid;
  logic                      out_ready;
  logic [CHAN_W-1:0]         out_red, out_green, out_blue, out_alpha;
  logic                      out_batch_end_out;

  // predictor state
  logic [TEXEL_W-1:0] texel_mem [0:65535];
  logic [SIZE_W-1:0]  cur_w, cur_h;
  logic [1:0]         mode_x, mode_y;
  pixel_t             pending_pixels[$];

  int  n_fail, n_samples, n_writes, n_checked, n_phases, cycles;
  bit  quiet, held;

  // directed requests, 1x1 clamp: all four taps hit texel 0
  dir_row_t dir_tab [DIR_N] = '{
    '{'{REQ_WRITE, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000,
        25'sh0FFFFFF, -25'sd16777216, 1'b1}, 0, '{0, 0, 0, 0, 0}},
    '{'{REQ_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        -25'sd16777216, 25'sh0FFFFFF, 1'b0}, 0, '{0, 0, 0, 0, 0}},
    '{'{REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        25'sd0, 25'sd0, 1'b0}, 1, '{16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 1'b0}},
    '{'{REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        -25'sd16777216, 25'sh0FFFFFF, 1'b1}, 1,
        '{16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 1'b1}},
    '{'{REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        25'sh0FFFFFF, -25'sd16777216, 1'b0}, 1,
        '{16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 1'b0}},
    '{'{REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        25'sd32768, 25'sd32768, 1'b1}, 1,
        '{16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 1'b1}},
    '{'{REQ_WRITE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
        25'sd0, 25'sd0, 1'b0}, 0, '{0, 0, 0, 0, 0}},
    '{'{REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        -25'sd1, 25'sd1, 1'b1}, 1, '{16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b1}},
    '{'{REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        25'sd65536, 25'sd65536, 1'b0}, 1, '{16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0}}
  };

  bilinear_texture_sampler_core dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYC) begin
        $display("timeout after %0d cycles", cycles);
        $display("[bilinear_texture_sampler_core] ERROR");
        $finish;
      end
    end
  end

  function automatic longint eff_size(logic [SIZE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > 256) return 256;
    return longint'(raw);
  endfunction

  function automatic longint wrap_axis(longint i, longint size, logic [1:0] mode);
    longint per, r;
    if (mode == WRAP_CLAMP) return (i < 0) ? 0 : (i >= size) ? size - 1 : i;
    per = (mode == WRAP_REPEAT) ? size : 2 * size;
    r = i % per;
    if (r < 0) r += per;
    if (mode == WRAP_REPEAT || r < size) return r;
    return per - 1 - r;
  endfunction

  // bilinear filter of one sample against the shadow store
  function automatic pixel_t filter_sample(tex_req_t q);
    pixel_t  p;
    longint  w, h, qx, qy, xi, yi, x0, x1, y0, y1;
    longint unsigned fx, fy, ix, iy, top, bot, acc;
    logic [TEXEL_W-1:0] t00, t01, t10, t11;
    logic [CHAN_W-1:0]  ch [4];
    w  = eff_size(cur_w);
    h  = eff_size(cur_h);
    qx = longint'(q.u) * w - 32768;
    qy = (65536 - longint'(q.v)) * h - 32768;
    xi = qx >>> 16;
    yi = qy >>> 16;
    fx = qx & 64'hFFFF;
    fy = qy & 64'hFFFF;
    x0 = wrap_axis(xi, w, mode_x);
    x1 = wrap_axis(xi + 1, w, mode_x);
    y0 = wrap_axis(yi, h, mode_y);
    y1 = wrap_axis(yi + 1, h, mode_y);
    ix = 65536 - fx;
    iy = 65536 - fy;
    t00 = texel_mem[16'(y0 * w + x0)];
    t01 = texel_mem[16'(y0 * w + x1)];
    t10 = texel_mem[16'(y1 * w + x0)];
    t11 = texel_mem[16'(y1 * w + x1)];
    for (int c = 0; c < 4; c++) begin
      top = t00[c*16 +: 16] * ix + t01[c*16 +: 16] * fx;
      bot = t10[c*16 +: 16] * ix + t11[c*16 +: 16] * fx;
      acc = top * iy + bot * fy;
      ch[c] = 16'((acc + 64'h8000_0000) >> 32);
    end
    p = '{ch[0], ch[1], ch[2], ch[3], q.be};
    return p;
  endfunction

  // offer one request, then apply it to the predictor once accepted
  task automatic send_req(tex_req_t q, bit known = 0, pixel_t pix = '{0, 0, 0, 0, 0});
    pixel_t p;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= q.kind;
    in_texel_index <= q.idx;
    in_texel_red   <= q.r;
    in_texel_green <= q.g;
    in_texel_blue  <= q.b;
    in_texel_alpha <= q.a;
    in_coord_u     <= q.u;
    in_coord_v     <= q.v;
    in_batch_end   <= q.be;
    do @(posedge clk); while (!in_ready);
    if (q.kind == REQ_WRITE) begin
      texel_mem[q.idx] = {q.a, q.b, q.g, q.r};
      n_writes++;
    end else begin
      p = filter_sample(q);
      pending_pixels.push_back(known ? pix : p);
      n_samples++;
    end
  endtask

  function automatic tex_req_t rand_req(logic kind);
    tex_req_t q;
    q.kind = kind;
    q.idx  = 16'($urandom);
    q.r    = 16'($urandom);
    q.g    = 16'($urandom);
    q.b    = 16'($urandom);
    q.a    = 16'($urandom);
    q.be   = 1'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      q.u = 25'($urandom);
      q.v = 25'($urandom);
    end else begin
      q.u = 25'(int'($urandom_range(0, 3 * 65536)) - 65536);
      q.v = 25'(int'($urandom_range(0, 3 * 65536)) - 65536);
    end
    return q;
  endfunction

  // wait for all samples to drain, then let writes leave the pipe
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_regs(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                            logic [1:0] wx, logic [1:0] wy);
    logic [SIZE_W-1:0] vals [4];
    vals = '{w, h, SIZE_W'(wx), SIZE_W'(wy)};
    drain_pipe();
    foreach (vals[i]) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_AW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_w  = w;
    cur_h  = h;
    mode_x = wx;
    mode_y = wy;
    n_phases++;
  endtask

  // load the whole area in use, then random traffic
  task automatic run_phase(int n_items);
    tex_req_t q;
    longint   area;
    area = eff_size(cur_w) * eff_size(cur_h);
    for (longint i = 0; i < area; i++) begin
      q = rand_req(REQ_WRITE);
      q.idx = 16'(i);
      send_req(q);
    end
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) < 7) q = rand_req(REQ_SAMPLE);
      else begin
        q = rand_req(REQ_WRITE);
        if ($urandom_range(0, 3) != 0) q.idx = 16'($urandom_range(0, int'(area) - 1));
      end
      send_req(q);
    end
  endtask

  // result checker
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %h want %h", n_checked, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("unexpected result %h %h %h %h", out_red, out_green, out_blue, out_alpha);
        n_fail++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_red !== e.r) report_mismatch("red", out_red, e.r);
        if (out_green !== e.g) report_mismatch("green", out_green, e.g);
        if (out_blue !== e.b) report_mismatch("blue", out_blue, e.b);
        if (out_alpha !== e.a) report_mismatch("alpha", out_alpha, e.a);
        if (out_batch_end_out !== e.be) report_mismatch("batch_end", out_batch_end_out, e.be);
      end
      n_checked++;
    end
  end

  // result side: random stalls plus one long hold-off to back up the pipe
  initial begin
    out_ready = 1'b0;
    held = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && n_samples >= 200) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        held = 1;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;  cfg_index = '0;  cfg_data = '0;
    in_valid = 1'b0;   in_req_type = REQ_WRITE;  in_texel_index = '0;
    in_texel_red = '0; in_texel_green = '0; in_texel_blue = '0; in_texel_alpha = '0;
    in_coord_u = '0;   in_coord_v = '0;   in_batch_end = 1'b0;
    n_fail = 0; n_samples = 0; n_writes = 0; n_checked = 0; n_phases = 0;
    quiet = 0;
    cur_w = 9'd1; cur_h = 9'd1; mode_x = WRAP_CLAMP; mode_y = WRAP_CLAMP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].pix);

    // fixed settings: extremes, oversize, zero size, unused wrap code
    write_regs(9'd4, 9'd3, WRAP_CLAMP, WRAP_REPEAT);   run_phase(60);
    write_regs(9'd300, 9'd1, WRAP_REPEAT, WRAP_MIRROR); run_phase(60);
    write_regs(9'd0, 9'd511, 2'd3, WRAP_CLAMP);         run_phase(60);
    write_regs(9'd256, 9'd2, WRAP_MIRROR, 2'd3);        run_phase(60);
    write_regs(9'd2, 9'd64, WRAP_REPEAT, WRAP_REPEAT);  run_phase(60);

    // random small settings; the last phase runs without any idling
    for (int ph = 0; ph < 7; ph++) begin
      write_regs(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      if (ph == 6) quiet = 1;
      run_phase(60);
    end

    drain_pipe();
    $display("covered %0d samples and %0d texel writes over %0d register settings",
             n_samples, n_writes, n_phases);
    $display("%0d results checked, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0 && pending_pixels.size() == 0) begin
      $display("[bilinear_texture_sampler_core] OK");
    end else begin
      $display("[bilinear_texture_sampler_core] ERROR");
    end
    $finish;
  end

endmodule
